[rtl/mandelbrot_pixel_shader_macros.svh]
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader assertion macros
// Concurrent assertion wrappers shared by the shader RTL; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_SHADER_MACROS_SVH
`define MANDELBROT_PIXEL_SHADER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define MPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define MPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/mps_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader package
// Register map, reset values and the types passed between shader modules.
// ----------------------------------------------------------------------------
package mps_pkg;

	// configuration register map
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_LVL = 3'd5;

	// reset values (Q4.28 view: -2.5, -1.5, 3/1024, 3/1024)
	localparam logic signed [31:0] RST_X_ORIGIN  = -32'sd671088640;
	localparam logic signed [31:0] RST_Y_ORIGIN  = -32'sd402653184;
	localparam logic [30:0]        RST_X_STEP    = 31'd786432;
	localparam logic [30:0]        RST_Y_STEP    = 31'd786432;
	localparam logic [15:0]        RST_ITER_LIM  = 16'd256;
	localparam logic [8:0]         RST_SHADE_LVL = 9'd256;

	typedef struct packed {
		logic signed [31:0] x_origin;
		logic signed [31:0] y_origin;
		logic [30:0]        x_step;
		logic [30:0]        y_step;
		logic [15:0]        iteration_limit;
		logic [8:0]         shade_levels;
	} cfg_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CMUL,
		OP_CADD,
		OP_ZMUL,
		OP_ZSTEP,
		OP_GD2,
		OP_GRHS,
		OP_GSQ,
		OP_GCMP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] bit_idx;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic z_done;
	} sts_t;

endpackage

[rtl/mandelbrot_pixel_shader.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader
// Escape-time shading of one pixel per input word, one result word per pixel.
// ----------------------------------------------------------------------------
// From one accepted pixel word to the next, a pixel goes through these steps.
// Setup accepts the word, forms the index products and sums c. Each step of
// the escape loop has two parts: first the three 32x32 products of z, then the
// saturating update and the |z|^2 test. A bit-serial search over the eight
// gray bits follows, and a final step hands the result over.
// One pixel is worked on at a time; the next pixel is taken as soon as the
// previous result sits in the output register, even if it is not yet read.
// Configuration writes are always taken and must only happen while idle.
module mandelbrot_pixel_shader #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 28,
	parameter int COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [COORD_BITS-1:0]           column,
	input  logic [COORD_BITS-1:0]           row,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      gray_level,
	output logic [COUNT_BITS-1:0]           inside_count
);

	mps_pkg::cfg_t cfg;
	mps_pkg::cmd_t cmd;
	mps_pkg::sts_t sts;
	logic [15:0]   count_w;

	mps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mps_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.cfg          (cfg),
		.cmd          (cmd),
		.column       (column),
		.row          (row),
		.sts          (sts),
		.gray_level   (gray_level),
		.inside_count (count_w)
	);

	// fit the count to the output width
	assign inside_count = COUNT_BITS'(count_w);

endmodule

[rtl/mps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader configuration registers
// Holds the view window, iteration limit and shade levels; writes always taken.
// ----------------------------------------------------------------------------
module mps_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data,
	output mps_pkg::cfg_t                       cfg
);

	mps_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// write one register per word; unknown indexes drop the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin        <= mps_pkg::RST_X_ORIGIN;
			cfg_q.y_origin        <= mps_pkg::RST_Y_ORIGIN;
			cfg_q.x_step          <= mps_pkg::RST_X_STEP;
			cfg_q.y_step          <= mps_pkg::RST_Y_STEP;
			cfg_q.iteration_limit <= mps_pkg::RST_ITER_LIM;
			cfg_q.shade_levels    <= mps_pkg::RST_SHADE_LVL;
		end else if (cfg_valid) begin
			case (cfg_index)
				mps_pkg::REG_X_ORIGIN:  cfg_q.x_origin        <= cfg_data;
				mps_pkg::REG_Y_ORIGIN:  cfg_q.y_origin        <= cfg_data;
				mps_pkg::REG_X_STEP:    cfg_q.x_step          <= cfg_data[30:0];
				mps_pkg::REG_Y_STEP:    cfg_q.y_step          <= cfg_data[30:0];
				mps_pkg::REG_ITER_LIM:  cfg_q.iteration_limit <= cfg_data[15:0];
				mps_pkg::REG_SHADE_LVL: cfg_q.shade_levels    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/mps_ctrl.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader controller
// Sequences coordinate setup, the escape loop, the gray search and output.
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_shader_macros.svh"

module mps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  mps_pkg::sts_t  sts,
	output mps_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMUL,
		ST_CADD,
		ST_ZMUL,
		ST_ZSTEP,
		ST_GD2,
		ST_GRHS,
		ST_GSQ,
		ST_GCMP,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [2:0] bit_q;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// decode the datapath operation for this cycle
	always_comb begin
		cmd = '{op: mps_pkg::OP_NONE, bit_idx: bit_q, load_out: 1'b0};
		case (state_q)
			ST_IDLE:  if (in_valid) cmd.op = mps_pkg::OP_LOAD;
			ST_CMUL:  cmd.op = mps_pkg::OP_CMUL;
			ST_CADD:  cmd.op = mps_pkg::OP_CADD;
			ST_ZMUL:  cmd.op = mps_pkg::OP_ZMUL;
			ST_ZSTEP: cmd.op = mps_pkg::OP_ZSTEP;
			ST_GD2:   cmd.op = mps_pkg::OP_GD2;
			ST_GRHS:  cmd.op = mps_pkg::OP_GRHS;
			ST_GSQ:   cmd.op = mps_pkg::OP_GSQ;
			ST_GCMP:  cmd.op = mps_pkg::OP_GCMP;
			ST_DONE:  cmd.load_out = slot_free;
			default: ;
		endcase
	end

	// advance the sequence and track the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_CMUL;
				ST_CMUL:  state_q <= ST_CADD;
				ST_CADD:  state_q <= ST_ZMUL;
				ST_ZMUL:  state_q <= ST_ZSTEP;
				ST_ZSTEP: state_q <= sts.z_done ? ST_GD2 : ST_ZMUL;
				ST_GD2:   state_q <= ST_GRHS;
				ST_GRHS: begin
					bit_q   <= 3'd7;
					state_q <= ST_GSQ;
				end
				ST_GSQ:   state_q <= ST_GCMP;
				ST_GCMP: begin
					if (bit_q == 3'd0) begin
						state_q <= ST_DONE;
					end else begin
						bit_q   <= bit_q - 3'd1;
						state_q <= ST_GSQ;
					end
				end
				ST_DONE:  if (slot_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	`MPS_ASSERT_NXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == ST_CMUL, "accepted word did not start setup")
	`MPS_ASSERT_NXT(a_escape_to_shade, clk, arst_n, state_q == ST_ZSTEP && sts.z_done, state_q == ST_GD2, "loop end did not start shading")
	`MPS_ASSERT_NXT(a_search_ends, clk, arst_n, state_q == ST_GCMP && bit_q == 3'd0, state_q == ST_DONE, "gray search overran")
	`MPS_ASSERT_NXT(a_result_posted, clk, arst_n, state_q == ST_DONE && slot_free, out_valid_q && state_q == ST_IDLE, "finished word not posted")

endmodule

[rtl/mps_dp.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader datapath
// Coordinate mapping, saturating Q-format iteration, escape test, gray search.
// ----------------------------------------------------------------------------
module mps_dp #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 28
) (
	input  logic                  clk,
	input  mps_pkg::cfg_t         cfg,
	input  mps_pkg::cmd_t         cmd,
	input  logic [COORD_BITS-1:0] column,
	input  logic [COORD_BITS-1:0] row,
	output mps_pkg::sts_t         sts,
	output logic [7:0]            gray_level,
	output logic [15:0]           inside_count
);

	localparam int PROD_W  = COORD_BITS + 31;
	localparam int THR_SH  = 2 * FRAC_BITS + 2;
	localparam bit CAN_ESC = (THR_SH <= 63);

	logic [COORD_BITS-1:0] col_q, row_q;
	logic [PROD_W-1:0]     px_q, py_q;
	logic signed [31:0]    cr_q, ci_q, zr_q, zi_q;
	logic signed [63:0]    srr_q, sii_q, sri_q;
	logic                  pend_q;
	logic [15:0]           count_q;
	logic [17:0]           sqt_q;
	logic [35:0]           rhs_q;
	logic [7:0]            gray_q, out_gray_q;
	logic [15:0]           out_count_q;

	logic signed [65:0]    cx_w, cy_w, nr_w, ni_w;
	logic signed [63:0]    sr_sh, si_sh, pri_sh;
	logic [63:0]           mag_sum;
	logic                  escaped;
	logic [15:0]           limit_c, lim_m1, count_inc, mul_b;
	logic [7:0]            d_w, trial;
	logic [8:0]            t_odd, sq_op;
	logic [17:0]           sq_res;
	logic [33:0]           mprod;
	logic                  take;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -66'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// c = origin + index * step
	assign cx_w = $signed({{34{cfg.x_origin[31]}}, cfg.x_origin})
		+ $signed({{(66 - PROD_W){1'b0}}, px_q});
	assign cy_w = $signed({{34{cfg.y_origin[31]}}, cfg.y_origin})
		+ $signed({{(66 - PROD_W){1'b0}}, py_q});

	// scale products back to the fixed-point grid (floor)
	assign sr_sh  = srr_q >>> FRAC_BITS;
	assign si_sh  = sii_q >>> FRAC_BITS;
	assign pri_sh = sri_q >>> (FRAC_BITS - 1);
	assign nr_w   = {{2{sr_sh[63]}}, sr_sh} - {{2{si_sh[63]}}, si_sh}
		+ {{34{cr_q[31]}}, cr_q};
	assign ni_w   = {{2{pri_sh[63]}}, pri_sh} + {{34{ci_q[31]}}, ci_q};

	// escape when |z|^2 reaches 4 at full product scale
	assign mag_sum = srr_q + sii_q;
	assign escaped = CAN_ESC && ((mag_sum >> THR_SH) != 64'd0);

	assign limit_c   = (cfg.iteration_limit < 16'd2) ? 16'd2 : cfg.iteration_limit;
	assign lim_m1    = limit_c - 16'd1;
	assign count_inc = pend_q ? count_q + 16'd1 : count_q;
	assign sts.z_done = (pend_q && escaped) || (count_inc == lim_m1);

	// gray search: largest g <= D with (2g-1)^2 * limit <= 4 * D^2 * count
	assign d_w = (cfg.shade_levels < 9'd2)   ? 8'd1 :
	             (cfg.shade_levels > 9'd256) ? 8'd255 : 8'(cfg.shade_levels - 9'd1);
	assign trial  = gray_q | (8'd1 << cmd.bit_idx);
	assign t_odd  = {trial, 1'b0} - 9'd1;
	assign sq_op  = (cmd.op == mps_pkg::OP_GSQ) ? t_odd : {1'b0, d_w};
	assign sq_res = sq_op * sq_op;
	assign mul_b  = (cmd.op == mps_pkg::OP_GRHS) ? count_q : limit_c;
	assign mprod  = sqt_q * mul_b;
	assign take   = (trial <= d_w) && ({2'b00, mprod} <= rhs_q);

	assign gray_level   = out_gray_q;
	assign inside_count = out_count_q;

	// execute the controller's operation
	always_ff @(posedge clk) begin
		case (cmd.op)
			mps_pkg::OP_LOAD: begin
				col_q <= column;
				row_q <= row;
			end
			mps_pkg::OP_CMUL: begin
				px_q <= col_q * cfg.x_step;
				py_q <= row_q * cfg.y_step;
			end
			mps_pkg::OP_CADD: begin
				cr_q    <= sat32(cx_w);
				ci_q    <= sat32(cy_w);
				zr_q    <= sat32(cx_w);
				zi_q    <= sat32(cy_w);
				pend_q  <= 1'b0;
				count_q <= 16'd1;
			end
			mps_pkg::OP_ZMUL: begin
				srr_q <= zr_q * zr_q;
				sii_q <= zi_q * zi_q;
				sri_q <= zr_q * zi_q;
			end
			mps_pkg::OP_ZSTEP: begin
				if (!(pend_q && escaped)) begin
					count_q <= count_inc;
					if (count_inc != lim_m1) begin
						zr_q   <= sat32(nr_w);
						zi_q   <= sat32(ni_w);
						pend_q <= 1'b1;
					end
				end
			end
			mps_pkg::OP_GD2: begin
				sqt_q  <= sq_res;
				gray_q <= 8'd0;
			end
			mps_pkg::OP_GRHS: rhs_q <= {mprod, 2'b00};
			mps_pkg::OP_GSQ:  sqt_q <= sq_res;
			mps_pkg::OP_GCMP: if (take) gray_q <= trial;
			default: ;
		endcase
		// hold the finished word for the output side
		if (cmd.load_out) begin
			out_gray_q  <= gray_q;
			out_count_q <= count_q;
		end
	end

endmodule

[tb/mandelbrot_shade_checker.sv]
// ----------------------------------------------------------------------------
// Mandelbrot shade checker
// Watches the configuration, pixel and result channels of the shader. It keeps
// a copy of the register file, works out the escape count and gray level of
// every accepted pixel, and compares each result word with the oldest one.
// ----------------------------------------------------------------------------
module mandelbrot_shade_checker #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 28,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [COORD_BITS-1:0]         column,
	input  logic [COORD_BITS-1:0]         row,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [7:0]                    gray_level,
	input  logic [COUNT_BITS-1:0]         inside_count,
	output int                            pending,
	output int                            fail_count,
	output int                            results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [7:0]            gray;
		logic [COUNT_BITS-1:0] count;
	} shade_t;

	mps_pkg::cfg_t view;
	shade_t        shade_q[$];
	int            errs;
	int            seen;

	function automatic longint clamp32(longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	function automatic longint unsigned sq_mag(longint v);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		return m * m;
	endfunction

	// escape count and gray level of one pixel under the current view
	function automatic shade_t shade_pixel(logic [COORD_BITS-1:0] col,
			logic [COORD_BITS-1:0] rw);
		longint          cr, ci, zr, zi, sr, si, pri;
		longint unsigned lim, lvl, d, thr, cnt, rhs, t, gray, it, k;
		shade_t          res;
		cr = clamp32(longint'($signed(view.x_origin)) + longint'(col) * longint'(view.x_step));
		ci = clamp32(longint'($signed(view.y_origin)) + longint'(rw) * longint'(view.y_step));
		lim = (view.iteration_limit < 2) ? 2 : view.iteration_limit;
		lvl = (view.shade_levels < 2) ? 2 : ((view.shade_levels > 256) ? 256 : view.shade_levels);
		d = lvl - 1;
		thr = (2 * FRAC_BITS + 2 <= 63) ? (64'd1 << (2 * FRAC_BITS + 2)) : '1;
		zr = cr;
		zi = ci;
		cnt = 1;
		// iterate z = z^2 + c until |z|^2 reaches 4
		for (it = 2; it < lim; it++) begin
			sr = longint'(sq_mag(zr) >> FRAC_BITS);
			si = longint'(sq_mag(zi) >> FRAC_BITS);
			pri = (zr * zi) >>> (FRAC_BITS - 1);
			zr = clamp32(sr - si + cr);
			zi = clamp32(pri + ci);
			if (sq_mag(zr) + sq_mag(zi) >= thr)
				break;
			cnt++;
		end
		// round half up of d*sqrt(cnt/lim), in integers
		rhs = 4 * d * d * cnt;
		gray = 0;
		for (k = 0; k < d; k++) begin
			t = 2 * k + 1;
			if (t * t * lim <= rhs)
				gray++;
			else
				break;
		end
		res.gray = gray[7:0];
		res.count = cnt[COUNT_BITS-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		shade_t want;
		if (!arst_n) begin
			view.x_origin <= mps_pkg::RST_X_ORIGIN;
			view.y_origin <= mps_pkg::RST_Y_ORIGIN;
			view.x_step <= mps_pkg::RST_X_STEP;
			view.y_step <= mps_pkg::RST_Y_STEP;
			view.iteration_limit <= mps_pkg::RST_ITER_LIM;
			view.shade_levels <= mps_pkg::RST_SHADE_LVL;
			shade_q.delete();
			errs = 0;
			seen = 0;
			pending <= 0;
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			// mirror register writes; spare indexes drop
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				mps_pkg::REG_X_ORIGIN: view.x_origin = cfg_data;
				mps_pkg::REG_Y_ORIGIN: view.y_origin = cfg_data;
				mps_pkg::REG_X_STEP: view.x_step = cfg_data[30:0];
				mps_pkg::REG_Y_STEP: view.y_step = cfg_data[30:0];
				mps_pkg::REG_ITER_LIM: view.iteration_limit = cfg_data[15:0];
				mps_pkg::REG_SHADE_LVL: view.shade_levels = cfg_data[8:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				shade_q.push_back(shade_pixel(column, row));
			// compare each result word with the oldest pixel in flight
			if (out_valid && out_ready) begin
				seen++;
				if (shade_q.size() == 0) begin
					$error("result word with no pixel in flight: gray_level %0d inside_count %0d",
						gray_level, inside_count);
					errs++;
				end else begin
					want = shade_q.pop_front();
					if (gray_level !== want.gray) begin
						$error("gray_level mismatch: expected %0d, actual %0d",
							want.gray, gray_level);
						errs++;
					end
					if (inside_count !== want.count) begin
						$error("inside_count mismatch: expected %0d, actual %0d",
							want.count, inside_count);
						errs++;
					end
				end
			end
			pending <= shade_q.size();
			fail_count <= errs;
			results_seen <= seen;
		end
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel shader testbench
// Drives pixel words and register writes into the shader under random
// back-pressure on both sides. A directed part covers the coordinate corners,
// saturated c, degenerate and maximal iteration limits and gray depths, and
// spare register indexes; random views of the set follow. The checker beside
// the shader predicts every result word and counts failures.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS     = 12;
	localparam int FRAC_BITS      = 28;
	localparam int COUNT_BITS     = 16;
	localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
	localparam int HOLD_CYCLES    = 2000;
	localparam int WATCHDOG_LIMIT = 500000;
	localparam int VIEWS_PER_MODE = 4;
	localparam int PIXELS_PER_VIEW = 33;

	// indexes past the end of the register map
	localparam logic [mps_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [mps_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [mps_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                   cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [COORD_BITS-1:0]         column;
	logic [COORD_BITS-1:0]         row;
	logic                          out_valid;
	logic                          out_ready;
	logic [7:0]                    gray_level;
	logic [COUNT_BITS-1:0]         inside_count;

	int pending;
	int fail_count;
	int results_seen;
	int src_idle_pct;
	int sink_idle_pct;
	bit hold_trigger;
	int n_sent;
	int n_views;

	mandelbrot_pixel_shader #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS(FRAC_BITS),
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.column(column),
		.row(row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gray_level(gray_level),
		.inside_count(inside_count)
	);

	mandelbrot_shade_checker #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS(FRAC_BITS),
		.COUNT_BITS(COUNT_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.column(column),
		.row(row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gray_level(gray_level),
		.inside_count(inside_count),
		.pending(pending),
		.fail_count(fail_count),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : sink
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_trigger && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// end the run when no word moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// offer one pixel word, after a random gap; valid stays up until taken
	task automatic send_pixel(int c, int r);
		int gap;
		gap = 0;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		column <= COORD_BITS'(c);
		row <= COORD_BITS'(r);
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// leave cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [mps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_view(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
			logic [31:0] ys, logic [31:0] lim, logic [31:0] lvl);
		write_reg(mps_pkg::REG_X_ORIGIN, xo);
		write_reg(mps_pkg::REG_Y_ORIGIN, yo);
		write_reg(mps_pkg::REG_X_STEP, xs);
		write_reg(mps_pkg::REG_Y_STEP, ys);
		write_reg(mps_pkg::REG_ITER_LIM, lim);
		write_reg(mps_pkg::REG_SHADE_LVL, lvl);
		cfg_valid <= 1'b0;
		n_views++;
	endtask

	// stop offering and wait until every pixel in flight has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly windows onto the set, sometimes raw register noise
	task automatic random_view();
		logic [31:0] xo, yo, xs, ys, lim, lvl;
		if ($urandom_range(3) != 0) begin
			xo = -$urandom_range(671088640);
			yo = -$urandom_range(402653184);
			xs = $urandom_range(1 << 18);
			ys = $urandom_range(1 << 18);
		end else begin
			xo = $urandom;
			yo = $urandom;
			xs = $urandom;
			ys = $urandom;
		end
		case ($urandom_range(3))
		0: lim = $urandom_range(16);
		1: lim = $urandom_range(300, 17);
		default: lim = $urandom_range(256, 64);
		endcase
		lvl = $urandom_range(511);
		load_view(xo, yo, xs, ys, lim, lvl);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = mps_pkg::REG_X_ORIGIN;
		cfg_data = '0;
		in_valid = 1'b0;
		column = '0;
		row = '0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_trigger = 1'b0;
		n_sent = 0;
		n_views = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: corners and a point deep inside the set
		send_pixel(0, 0);
		send_pixel(COORD_MAX, COORD_MAX);
		send_pixel(0, COORD_MAX);
		send_pixel(COORD_MAX, 0);
		send_pixel(853, 512);
		drain();

		// saturated c, limit and depth below the floor, spare indexes
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		load_view(32'h7FFF_FFFF, 32'h8000_0000, '1, '1, 0, 0);
		send_pixel(COORD_MAX, COORD_MAX);
		send_pixel(0, 0);
		send_pixel(1, 1);
		drain();

		// c at zero, limit of one, depth above the ceiling
		load_view(0, 0, 0, 0, 1, 511);
		send_pixel(COORD_MAX, 0);
		send_pixel(0, COORD_MAX);
		drain();

		// full-length loop at the largest limit
		load_view(0, 0, 1, 1, 65535, 256);
		send_pixel(0, 0);
		drain();

		// shortest loop, depth just over the ceiling
		load_view(mps_pkg::RST_X_ORIGIN, mps_pkg::RST_Y_ORIGIN,
			32'(mps_pkg::RST_X_STEP), 32'(mps_pkg::RST_Y_STEP), 2, 257);
		send_pixel(853, 512);
		send_pixel(COORD_MAX, COORD_MAX);
		drain();

		// largest limit with pixels that escape at once, two levels
		load_view(32'h2000_0000, 0, 1 << 20, 1 << 20, 65535, 2);
		send_pixel(0, 0);
		send_pixel(COORD_MAX, COORD_MAX);
		drain();

		// random views under three stall patterns
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
			0: begin
				src_idle_pct = 12;
				sink_idle_pct = 54;
			end
			1: begin
				src_idle_pct = 54;
				sink_idle_pct = 12;
			end
			default: begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			endcase
			for (int v = 0; v < VIEWS_PER_MODE; v++) begin
				random_view();
				if (mode == 0 && v == 0)
					hold_trigger = 1'b1;
				for (int p = 0; p < PIXELS_PER_VIEW; p++)
					send_pixel($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
				drain();
			end
		end

		repeat (30) @(posedge clk);
		$display("Shaded %0d pixels under %0d register views, %0d result words compared.",
			n_sent, n_views, results_seen);
		$display("Views spanned saturated c, limits 0 to 65535, depths 0 to 511 and an output hold-off.");
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
